@@ hw/rtl/bts_pkg.sv @@
// ---------------------------------------------------------------------------
// Bilinear texture sampler package
// Item, result and texel types, plus register indexes and queue depths
// shared by the sampler's modules.
// ---------------------------------------------------------------------------
package bts_pkg;

    // One input item: either a texel write or a sample request.
    typedef struct packed {
        logic               kind;
        logic [7:0]         texel_x;
        logic [7:0]         texel_y;
        logic [15:0]        write_red;
        logic [15:0]        write_green;
        logic [15:0]        write_blue;
        logic signed [19:0] coord_u;
        logic signed [19:0] coord_v;
        logic               clamp_u;
        logic               clamp_v;
    } t_in_item;

    // One filtered result.
    typedef struct packed {
        logic [15:0] sample_red;
        logic [15:0] sample_green;
        logic [15:0] sample_blue;
    } t_result;

    // One stored texel, three Q4.12 channels.
    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_texel;

    // Item kinds.
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Configuration port layout and register indexes.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IN_USE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IN_USE = 4'd1;

    // Queue depths.
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

endpackage

@@ hw/rtl/bts_ram.sv @@
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module bts_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bts_queue.sv @@
// ---------------------------------------------------------------------------
// Small register queue
// First-in first-out buffer with full and empty flags.
// ---------------------------------------------------------------------------
module bts_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and occupancy update.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

@@ hw/rtl/bts_front.sv @@
// ---------------------------------------------------------------------------
// Sampler front end
// Holds the size registers and maps each accepted sample's coordinates
// onto the texture, giving scaled fixed-point positions for the back end.
// ---------------------------------------------------------------------------
module bts_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 16,
    parameter int SWW        = $clog2(MAX_WIDTH + 1),
    parameter int SHW        = $clog2(MAX_HEIGHT + 1),
    parameter int CW         = ((FRAC_BITS + 1) > 20) ? (FRAC_BITS + 1) : 20,
    parameter int PXW        = CW + SWW + 1,
    parameter int PYW        = CW + SHW + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [bts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  bts_pkg::t_in_item              i_item,
    output logic [SWW-1:0]                 o_width,
    output logic [SHW-1:0]                 o_height,
    output logic signed [PXW-1:0]          o_px,
    output logic signed [PYW-1:0]          o_py
);

    import bts_pkg::*;

    localparam int W_RESET = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;
    localparam int H_RESET = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;

    logic [SWW-1:0]       r_width, n_width;
    logic [SHW-1:0]       r_height, n_height;
    logic signed [CW-1:0] cu_full, cv_full, cu_sel, cv_sel;

    // The size registers hold the effective size: zero reads as one and
    // values above the store's extent saturate.
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_valid && i_cfg_index == CFG_WIDTH_IN_USE) begin
            if (i_cfg_data == '0) begin
                n_width = SWW'(1);
            end else if (32'(i_cfg_data) > MAX_WIDTH) begin
                n_width = SWW'(MAX_WIDTH);
            end else begin
                n_width = SWW'(i_cfg_data);
            end
        end
        if (i_cfg_valid && i_cfg_index == CFG_HEIGHT_IN_USE) begin
            if (i_cfg_data == '0) begin
                n_height = SHW'(1);
            end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
                n_height = SHW'(MAX_HEIGHT);
            end else begin
                n_height = SHW'(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SWW'(W_RESET);
            r_height <= SHW'(H_RESET);
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    // Wrap mode keeps the low fraction bits only, which is floor modulo one.
    always_comb begin
        cu_full = CW'(i_item.coord_u);
        cv_full = CW'(i_item.coord_v);
        cu_sel  = i_item.clamp_u ? cu_full
                                 : {{(CW - FRAC_BITS){1'b0}}, cu_full[FRAC_BITS-1:0]};
        cv_sel  = i_item.clamp_v ? cv_full
                                 : {{(CW - FRAC_BITS){1'b0}}, cv_full[FRAC_BITS-1:0]};
    end

    // Scale each coordinate by the size in use; one multiplier per axis.
    assign o_px = PXW'(cu_sel) * $signed({1'b0, r_width});
    assign o_py = PYW'(cv_sel) * $signed({1'b0, r_height});

    assign o_width  = r_width;
    assign o_height = r_height;

endmodule

@@ hw/rtl/bts_back.sv @@
// ---------------------------------------------------------------------------
// Sampler back end
// Stores texel writes, clamps neighbour indices, reads four texel banks and
// filters the four texels, first along x and then along y.
// ---------------------------------------------------------------------------
module bts_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 16,
    parameter int SWW        = $clog2(MAX_WIDTH + 1),
    parameter int SHW        = $clog2(MAX_HEIGHT + 1),
    parameter int PXW        = 30,
    parameter int PYW        = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [SWW-1:0]        i_width,
    input  logic [SHW-1:0]        i_height,
    input  logic                  i_head_valid,
    input  logic                  i_kind,
    input  logic signed [PXW-1:0] i_px,
    input  logic signed [PYW-1:0] i_py,
    input  logic [7:0]            i_wx,
    input  logic [7:0]            i_wy,
    input  bts_pkg::t_texel       i_wtexel,
    output logic                  o_head_pop,
    input  logic                  i_res_taken,
    output logic                  o_res_valid,
    output bts_pkg::t_result      o_res
);

    import bts_pkg::*;

    // Index widths: column and row, then the coordinate inside a bank.
    localparam int CXW  = $clog2(MAX_WIDTH);
    localparam int CYW  = $clog2(MAX_HEIGHT);
    localparam int KXW  = (CXW > 1) ? CXW - 1 : 1;
    localparam int KYW  = (CYW > 1) ? CYW - 1 : 1;
    localparam int KDEP = 1 << (KXW + KYW);
    localparam int IXW  = PXW - FRAC_BITS;
    localparam int IYW  = PYW - FRAC_BITS;
    localparam int IMW  = (IXW > IYW) ? IXW : IYW;
    localparam int LW   = FRAC_BITS + 19;
    localparam int UW   = $clog2(OUT_DEPTH + 1);
    localparam logic signed [LW-1:0] LERP_HALF = LW'(1) <<< (FRAC_BITS - 1);

    // Clamp a floor index into [0, size-1].
    function automatic logic [IMW-1:0] clamp_idx(input logic signed [IMW-1:0] idx,
                                                 input logic signed [IMW-1:0] size);
        logic [IMW-1:0] res;
        if (idx < 0) begin
            res = '0;
        end else if (idx >= size) begin
            res = size - 1'b1;
        end else begin
            res = idx;
        end
        return res;
    endfunction

    // Rounded lerp written as a + (b - a) * t, which equals
    // a * (1 - t) + b * t exactly.
    function automatic logic [15:0] lerp(input logic [15:0] a, input logic [15:0] b,
                                         input logic [FRAC_BITS-1:0] t);
        logic signed [16:0]   diff;
        logic signed [LW-1:0] acc;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        acc  = $signed(LW'(diff)) * $signed({1'b0, t})
             + $signed({2'b00, a, {FRAC_BITS{1'b0}}}) + LERP_HALF;
        return acc[FRAC_BITS +: 16];
    endfunction

    // Issue control: writes go at once, samples need an output credit.
    logic [UW-1:0] r_used, n_used;
    logic          issue_sample;

    assign issue_sample = i_head_valid && (i_kind == KIND_SAMPLE) && (r_used < UW'(OUT_DEPTH));
    assign o_head_pop   = i_head_valid && ((i_kind == KIND_WRITE) || issue_sample);

    always_comb begin
        n_used = r_used;
        if (issue_sample && !i_res_taken) begin
            n_used = r_used + 1'b1;
        end else if (!issue_sample && i_res_taken) begin
            n_used = r_used - 1'b1;
        end
    end

    // Floor and weight split, then neighbour clamping.
    logic signed [IXW-1:0] base_x, base_x1;
    logic signed [IYW-1:0] base_y, base_y1;
    logic [CXW-1:0]        x0, x1;
    logic [CYW-1:0]        y0, y1;
    logic                  wr_ok;

    always_comb begin
        base_x  = IXW'(i_px >>> FRAC_BITS);
        base_y  = IYW'(i_py >>> FRAC_BITS);
        base_x1 = base_x + 1'b1;
        base_y1 = base_y + 1'b1;
        x0 = CXW'(clamp_idx(IMW'(base_x), IMW'(i_width)));
        x1 = CXW'(clamp_idx(IMW'(base_x1), IMW'(i_width)));
        y0 = CYW'(clamp_idx(IMW'(base_y), IMW'(i_height)));
        y1 = CYW'(clamp_idx(IMW'(base_y1), IMW'(i_height)));
        wr_ok = (32'(i_wx) < MAX_WIDTH) && (32'(i_wy) < MAX_HEIGHT);
    end

    // Stage one: indices and weights, or a pending texel write.
    logic                 r_b1_valid, r_b1_wen;
    logic [CXW-1:0]       r_b1_x0, r_b1_x1, r_b1_wx;
    logic [CYW-1:0]       r_b1_y0, r_b1_y1, r_b1_wy;
    logic [FRAC_BITS-1:0] r_b1_tx, r_b1_ty;
    t_texel               r_b1_wdata;

    // Stage two: bank parities of the neighbours and the weights.
    logic                 r_b2_valid;
    logic                 r_b2_x0p, r_b2_x1p, r_b2_y0p, r_b2_y1p;
    logic [FRAC_BITS-1:0] r_b2_tx, r_b2_ty;

    // Stage three: the two rows filtered along x.
    logic                 r_b3_valid;
    logic [FRAC_BITS-1:0] r_b3_ty;
    t_texel               r_b3_top, r_b3_bot;

    // Neighbour texels and the two row results feeding stage three.
    t_texel t00, t01, t10, t11, n_top, n_bot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_b1_valid <= 1'b0;
            r_b1_wen   <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
        end else begin
            r_used     <= n_used;
            r_b1_valid <= issue_sample;
            r_b1_wen   <= o_head_pop && (i_kind == KIND_WRITE) && wr_ok;
            r_b2_valid <= r_b1_valid;
            r_b3_valid <= r_b2_valid;
        end
    end

    // Texel banks, one for each parity of column and row.
    logic [KXW+KYW-1:0] bank_raddr [4];
    logic [KXW+KYW-1:0] bank_waddr;
    t_texel             bank_q     [4];
    logic [1:0]         wbank;

    assign wbank      = {r_b1_wy[0], r_b1_wx[0]};
    assign bank_waddr = {KYW'(r_b1_wy >> 1), KXW'(r_b1_wx >> 1)};

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [CXW-1:0] col;
        logic [CYW-1:0] row;
        logic [47:0]    rdata;

        // Each bank holds the neighbour column and row of its own parity.
        assign col = (r_b1_x0[0] == k[0]) ? r_b1_x0 : r_b1_x1;
        assign row = (r_b1_y0[0] == k[1]) ? r_b1_y0 : r_b1_y1;
        assign bank_raddr[k] = {KYW'(row >> 1), KXW'(col >> 1)};

        bts_ram #(
            .WIDTH(48),
            .DEPTH(KDEP)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (r_b1_wen && (wbank == 2'(k))),
            .i_waddr(bank_waddr),
            .i_wdata(r_b1_wdata),
            .i_raddr(bank_raddr[k]),
            .o_rdata(rdata)
        );

        assign bank_q[k] = t_texel'(rdata);
    end

    // Payload registers of the pipeline.
    always_ff @(posedge i_clk) begin
        r_b1_x0    <= x0;
        r_b1_x1    <= x1;
        r_b1_y0    <= y0;
        r_b1_y1    <= y1;
        r_b1_tx    <= i_px[FRAC_BITS-1:0];
        r_b1_ty    <= i_py[FRAC_BITS-1:0];
        r_b1_wx    <= CXW'(i_wx);
        r_b1_wy    <= CYW'(i_wy);
        r_b1_wdata <= i_wtexel;
        r_b2_x0p   <= r_b1_x0[0];
        r_b2_x1p   <= r_b1_x1[0];
        r_b2_y0p   <= r_b1_y0[0];
        r_b2_y1p   <= r_b1_y1[0];
        r_b2_tx    <= r_b1_tx;
        r_b2_ty    <= r_b1_ty;
        r_b3_ty    <= r_b2_ty;
        r_b3_top   <= n_top;
        r_b3_bot   <= n_bot;
    end

    // Route bank data to the four neighbours and filter along x.
    always_comb begin
        t00 = bank_q[{r_b2_y0p, r_b2_x0p}];
        t01 = bank_q[{r_b2_y0p, r_b2_x1p}];
        t10 = bank_q[{r_b2_y1p, r_b2_x0p}];
        t11 = bank_q[{r_b2_y1p, r_b2_x1p}];
        n_top.red   = lerp(t00.red,   t01.red,   r_b2_tx);
        n_top.green = lerp(t00.green, t01.green, r_b2_tx);
        n_top.blue  = lerp(t00.blue,  t01.blue,  r_b2_tx);
        n_bot.red   = lerp(t10.red,   t11.red,   r_b2_tx);
        n_bot.green = lerp(t10.green, t11.green, r_b2_tx);
        n_bot.blue  = lerp(t10.blue,  t11.blue,  r_b2_tx);
    end

    // Filter along y on the rounded row results.
    always_comb begin
        o_res.sample_red   = lerp(r_b3_top.red,   r_b3_bot.red,   r_b3_ty);
        o_res.sample_green = lerp(r_b3_top.green, r_b3_bot.green, r_b3_ty);
        o_res.sample_blue  = lerp(r_b3_top.blue,  r_b3_bot.blue,  r_b3_ty);
    end

    assign o_res_valid = r_b3_valid;

endmodule

@@ hw/rtl/bilinear_texture_sampler_top.sv @@
// ---------------------------------------------------------------------------
// Bilinear texture sampler
// Texel store with clamp or wrap addressing and bilinear RGB filtering.
// ---------------------------------------------------------------------------
// Usage:
//   Items enter through push/full. A write item stores one texel and gives
//   no result; a sample item gives one filtered RGB result. Results leave
//   through empty/pop; the oldest result is on o_result while empty is low.
//   Size registers are written through the configuration channel, whose
//   ready is always high; write them only while the block is idle.
// Timing:
//   One item is taken every cycle while full is low; the rate is set by
//   the four texel banks, each giving one read a cycle, and by the
//   pipelined lerp stages.
// Reset:
//   Queues empty and the sizes return to 256 (or the store's extent).
//   Texel contents are undefined until written.
// Stalls:
//   Results wait in an eight-entry output queue. Samples are issued only
//   while a place in it is reserved, so when the receiver stops taking
//   results the four-entry middle queue fills and full rises.
// ---------------------------------------------------------------------------
module bilinear_texture_sampler_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  bts_pkg::t_in_item              i_item,
    output logic                           empty,
    input  logic                           pop,
    output bts_pkg::t_result               o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import bts_pkg::*;

    localparam int SWW = $clog2(MAX_WIDTH + 1);
    localparam int SHW = $clog2(MAX_HEIGHT + 1);
    localparam int CW  = ((FRAC_BITS + 1) > 20) ? (FRAC_BITS + 1) : 20;
    localparam int PXW = CW + SWW + 1;
    localparam int PYW = CW + SHW + 1;
    localparam int MW  = 1 + PXW + PYW + 16 + 48;

    logic                  accept;
    logic [SWW-1:0]        width;
    logic [SHW-1:0]        height;
    logic signed [PXW-1:0] front_px;
    logic signed [PYW-1:0] front_py;
    t_texel                front_texel;
    logic [MW-1:0]         mid_in, mid_out;
    logic                  mid_full, mid_empty, mid_pop;
    logic                  head_kind;
    logic signed [PXW-1:0] head_px;
    logic signed [PYW-1:0] head_py;
    logic [7:0]            head_wx, head_wy;
    t_texel                head_texel;
    logic                  res_valid, out_full;
    t_result               res;
    logic [47:0]           out_data;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;
    assign full        = mid_full;

    // Front end: size registers and coordinate scaling.
    bts_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .FRAC_BITS (FRAC_BITS),
        .SWW       (SWW),
        .SHW       (SHW),
        .CW        (CW),
        .PXW       (PXW),
        .PYW       (PYW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid && o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .o_width    (width),
        .o_height   (height),
        .o_px       (front_px),
        .o_py       (front_py)
    );

    // Middle queue between the front and back ends.
    assign front_texel = {i_item.write_red, i_item.write_green, i_item.write_blue};
    assign mid_in      = {i_item.kind, front_px, front_py, i_item.texel_x, i_item.texel_y,
                          front_texel};

    bts_queue #(
        .WIDTH(MW),
        .DEPTH(MID_DEPTH)
    ) u_mid_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_data (mid_in),
        .i_pop  (mid_pop),
        .o_data (mid_out),
        .o_full (mid_full),
        .o_empty(mid_empty)
    );

    assign {head_kind, head_px, head_py, head_wx, head_wy, head_texel} = mid_out;

    // Back end: texel banks and filtering.
    bts_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .FRAC_BITS (FRAC_BITS),
        .SWW       (SWW),
        .SHW       (SHW),
        .PXW       (PXW),
        .PYW       (PYW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (width),
        .i_height    (height),
        .i_head_valid(!mid_empty),
        .i_kind      (head_kind),
        .i_px        (head_px),
        .i_py        (head_py),
        .i_wx        (head_wx),
        .i_wy        (head_wy),
        .i_wtexel    (head_texel),
        .o_head_pop  (mid_pop),
        .i_res_taken (pop && !empty),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output queue holding finished results.
    bts_queue #(
        .WIDTH(48),
        .DEPTH(OUT_DEPTH)
    ) u_out_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_valid),
        .i_data (res),
        .i_pop  (pop),
        .o_data (out_data),
        .o_full (out_full),
        .o_empty(empty)
    );

    assign o_result = t_result'(out_data);

    // The credit count must keep every finished result from meeting a full
    // output queue.
    a_no_result_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !out_full)
        else $error("result finished while the output queue was full");

    // The back end must take items from the middle queue only when it holds one.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_pop |-> !mid_empty)
        else $error("middle queue popped while empty");

    // A result leaves the back end after its sample passes stages one to three, so one
    // cannot appear while the middle queue has stayed empty over all of those stages.
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mid_empty && $past(mid_empty) && $past(mid_empty, 2) && $past(mid_empty, 3)
         && $past(i_rst_n, 3)) |-> !res_valid)
        else $error("result produced without an issued sample");

endmodule

@@ verif/tb.sv @@
// ---------------------------------------------------------------------------
// Bilinear texture sampler testbench
// Drives texel writes and sample requests into the sampler, keeps its own
// copy of the texel store and size registers, predicts every filtered
// result and compares each result transfer field by field. Both sides idle
// at random, and the output side is held off long enough to fill the block.
// ---------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bts_pkg::*;

    // Store extent and fixed-point layout of the block under test.
    localparam int TEX_W = 256;
    localparam int TEX_H = 256;
    localparam int FRAC_W = 16;
    localparam longint FRAC_MASK = (longint'(1) << FRAC_W) - 1;
    localparam longint unsigned ONE = longint'(1) << FRAC_W;

    // Register index that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 4'd9;

    localparam int IDLE_PCT = 33;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_CYCLES = 300;

    // Texel neighbourhood and weights of one sample.
    typedef struct {
        int x0;
        int x1;
        int y0;
        int y1;
        longint unsigned tx;
        longint unsigned ty;
    } t_footprint;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    t_in_item i_item;
    logic empty;
    logic pop;
    t_result o_result;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Shadow copy of the block's state.
    t_texel texels[TEX_W*TEX_H];
    bit written[TEX_W*TEX_H];
    logic [8:0] width_reg = 9'd256;
    logic [8:0] height_reg = 9'd256;

    t_result samples_due[$];
    int err_count = 0;
    bit no_idle = 1'b0;
    bit hold_kick = 1'b0;
    bit hold_seen = 1'b0;
    int stall_left = 0;

    bilinear_texture_sampler_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #5_000_000;
        $display("bilinear_texture_sampler_top verification failed");
        $finish;
    end

    // Size register value as the block applies it.
    function automatic int size_in_use(logic [8:0] r, int max_size);
        if (r == 0) return 1;
        if (r > max_size) return max_size;
        return int'(r);
    endfunction

    function automatic int clip_index(longint i, int size);
        if (i < 0) return 0;
        if (i > size - 1) return size - 1;
        return int'(i);
    endfunction

    // One axis: optional wrap to the fraction, scale, floor and clamp.
    function automatic void map_axis(input logic signed [19:0] coord, input logic clamp_bit,
                                     input int size, output int lo, output int hi,
                                     output longint unsigned wt);
        longint c;
        longint p;
        c = coord;
        if (!clamp_bit) c = c & FRAC_MASK;
        p = c * size;
        wt = longint'(p & FRAC_MASK);
        lo = clip_index(p >>> FRAC_W, size);
        hi = clip_index((p >>> FRAC_W) + 1, size);
    endfunction

    function automatic t_footprint footprint(t_in_item it);
        t_footprint fp;
        int lo;
        int hi;
        longint unsigned wt;
        map_axis(it.coord_u, it.clamp_u, size_in_use(width_reg, TEX_W), lo, hi, wt);
        fp.x0 = lo;
        fp.x1 = hi;
        fp.tx = wt;
        map_axis(it.coord_v, it.clamp_v, size_in_use(height_reg, TEX_H), lo, hi, wt);
        fp.y0 = lo;
        fp.y1 = hi;
        fp.ty = wt;
        return fp;
    endfunction

    // Linear interpolation, rounding half up.
    function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                              longint unsigned t);
        return (a * (ONE - t) + b * t + (ONE >> 1)) >> FRAC_W;
    endfunction

    // Two lerps along x on rounded values, then one along y.
    function automatic logic [15:0] lerp2d(logic [15:0] c00, logic [15:0] c01,
                                           logic [15:0] c10, logic [15:0] c11,
                                           longint unsigned tx, longint unsigned ty);
        return 16'(blend(blend(c00, c01, tx), blend(c10, c11, tx), ty));
    endfunction

    function automatic t_result bilinear_expect(t_in_item it);
        t_footprint fp;
        t_texel a;
        t_texel b;
        t_texel c;
        t_texel d;
        t_result r;
        fp = footprint(it);
        a = texels[fp.y0*TEX_W + fp.x0];
        b = texels[fp.y0*TEX_W + fp.x1];
        c = texels[fp.y1*TEX_W + fp.x0];
        d = texels[fp.y1*TEX_W + fp.x1];
        r.sample_red = lerp2d(a.red, b.red, c.red, d.red, fp.tx, fp.ty);
        r.sample_green = lerp2d(a.green, b.green, c.green, d.green, fp.tx, fp.ty);
        r.sample_blue = lerp2d(a.blue, b.blue, c.blue, d.blue, fp.tx, fp.ty);
        return r;
    endfunction

    // Random values; channels and coordinates are weighted towards their edges.
    function automatic t_in_item noise_item();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return bits[$bits(t_in_item)-1:0];
    endfunction

    function automatic logic [15:0] rand_channel();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [19:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return 20'($urandom);
            1: return 20'($urandom_range(0, 16'hFFFF));
            2: return 20'(int'($urandom_range(0, 600)) - 300);
            3: return 20'(int'(ONE) + int'($urandom_range(0, 600)) - 300);
            default: begin
                case ($urandom_range(0, 5))
                    0: return 20'h80000;
                    1: return 20'h7FFFF;
                    2: return 20'hFFFFF;
                    3: return 20'h00000;
                    4: return 20'h10000;
                    default: return 20'hF0000;
                endcase
            end
        endcase
    endfunction

    function automatic t_in_item texel_write(int x, int y, logic [15:0] r, logic [15:0] g,
                                             logic [15:0] b);
        t_in_item it;
        it = noise_item();
        it.kind = KIND_WRITE;
        it.texel_x = 8'(x);
        it.texel_y = 8'(y);
        it.write_red = r;
        it.write_green = g;
        it.write_blue = b;
        return it;
    endfunction

    function automatic t_in_item random_write(int w, int h);
        if ($urandom_range(0, 1))
            return texel_write($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                               rand_channel(), rand_channel(), rand_channel());
        return texel_write($urandom_range(0, 255), $urandom_range(0, 255),
                           rand_channel(), rand_channel(), rand_channel());
    endfunction

    function automatic t_in_item random_sample();
        t_in_item it;
        it = noise_item();
        it.kind = KIND_SAMPLE;
        it.coord_u = rand_coord();
        it.coord_v = rand_coord();
        return it;
    endfunction

    // One input transfer; the shadow state is updated when it is accepted.
    task automatic send_item(input t_in_item it);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        if (it.kind == KIND_WRITE) begin
            texels[{it.texel_y, it.texel_x}] = '{it.write_red, it.write_green, it.write_blue};
            written[{it.texel_y, it.texel_x}] = 1'b1;
        end else begin
            samples_due.push_back(bilinear_expect(it));
        end
    endtask

    // Texels that a sample would read are written first if still unknown.
    task automatic send_sample(input t_in_item it);
        t_footprint fp;
        int xs[2];
        int ys[2];
        fp = footprint(it);
        xs = '{fp.x0, fp.x1};
        ys = '{fp.y0, fp.y1};
        foreach (ys[j]) begin
            foreach (xs[i]) begin
                if (!written[ys[j]*TEX_W + xs[i]])
                    send_item(texel_write(xs[i], ys[j], rand_channel(), rand_channel(),
                                          rand_channel()));
            end
        end
        send_item(it);
    endtask

    task automatic sample_at(input logic [19:0] u, input logic [19:0] v,
                             input logic cu, input logic cv);
        t_in_item it;
        it = noise_item();
        it.kind = KIND_SAMPLE;
        it.coord_u = u;
        it.coord_v = v;
        it.clamp_u = cu;
        it.clamp_v = cv;
        send_sample(it);
    endtask

    // Stop sending and let every outstanding result and write complete.
    task automatic wait_drained();
        push <= 1'b0;
        while (samples_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One configuration transfer; valid is left high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        if (idx == CFG_WIDTH_IN_USE) width_reg = val;
        else if (idx == CFG_HEIGHT_IN_USE) height_reg = val;
    endtask

    task automatic set_sizes(input logic [8:0] w, input logic [8:0] h);
        wait_drained();
        write_reg(CFG_WIDTH_IN_USE, w);
        write_reg(CFG_HEIGHT_IN_USE, h);
        i_cfg_valid <= 1'b0;
    endtask

    // Compare one result field with its prediction.
    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (samples_due.size() == 0) begin
            $display("%0t: result %h with no sample outstanding, expected none", $time,
                     o_result);
            err_count++;
        end else begin
            want = samples_due.pop_front();
            compare_field("sample_red", want.sample_red, o_result.sample_red);
            compare_field("sample_green", want.sample_green, o_result.sample_green);
            compare_field("sample_blue", want.sample_blue, o_result.sample_blue);
        end
    endtask

    // Result side: check each transfer, then choose pop for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && empty === 1'b0) check_result();
        if (hold_kick != hold_seen) begin
            hold_seen = hold_kick;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
        end else begin
            pop <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Reset sizes, channel extremes, exact weights, floor of negative
    // coordinates, clamping past both edges and wrapping of negatives.
    task automatic test_reset_sizes();
        send_item(texel_write(0, 0, 16'h0000, 16'h0000, 16'h0000));
        send_item(texel_write(1, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(texel_write(0, 1, 16'hFFFF, 16'h0000, 16'h8000));
        send_item(texel_write(1, 1, 16'h0001, 16'hFFFF, 16'h7FFF));
        send_item(texel_write(255, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(texel_write(254, 255, 16'h0000, 16'h1234, 16'hABCD));
        sample_at(20'h00000, 20'h00000, 1'b1, 1'b1);
        sample_at(20'h00080, 20'h00080, 1'b1, 1'b1);
        sample_at(20'h00040, 20'h000C0, 1'b1, 1'b1);
        sample_at(20'h7FFFF, 20'h7FFFF, 1'b1, 1'b1);
        sample_at(20'h80000, 20'h80000, 1'b1, 1'b1);
        sample_at(20'hFFF80, 20'hFFF80, 1'b1, 1'b1);
        sample_at(20'h7FFFF, 20'h7FFFF, 1'b0, 1'b0);
        sample_at(20'hFFF80, 20'h00080, 1'b0, 1'b1);
        sample_at(20'h10000, 20'h0FFFF, 1'b1, 1'b0);
        sample_at(20'h80000, 20'h80000, 1'b0, 1'b0);
    endtask

    // A zero size acts as one, an oversized one saturates, and an
    // undecoded register index changes nothing.
    task automatic test_size_limits();
        wait_drained();
        write_reg(CFG_IDX_UNUSED, 9'h155);
        write_reg(CFG_WIDTH_IN_USE, 9'd0);
        write_reg(CFG_HEIGHT_IN_USE, 9'h1FF);
        i_cfg_valid <= 1'b0;
        sample_at(20'h0ABCD, 20'h7FFFF, 1'b1, 1'b1);
        sample_at(20'h08000, 20'h08000, 1'b0, 1'b0);
        send_sample(random_sample());
        set_sizes(9'h1FF, 9'd0);
        sample_at(20'h0FF80, 20'h00000, 1'b0, 1'b1);
        sample_at(20'hFFF80, 20'h7FFFF, 1'b1, 1'b1);
        send_sample(random_sample());
    endtask

    // Random mixes of writes and samples over a range of texture sizes.
    task automatic test_random_phases();
        int w;
        int h;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin w = 1; h = 1; end
                1: begin w = 256; h = 2; end
                2: begin w = 2; h = 256; end
                3: begin w = 256; h = 256; end
                default: begin
                    w = $urandom_range(1, 16);
                    h = $urandom_range(1, 16);
                end
            endcase
            set_sizes(9'(w), 9'(h));
            repeat (80) begin
                if ($urandom_range(0, 99) < 30) send_item(random_write(w, h));
                else send_sample(random_sample());
            end
        end
    endtask

    // A long stretch with neither side idling.
    task automatic test_back_to_back();
        int w;
        int h;
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
        set_sizes(9'(w), 9'(h));
        no_idle = 1'b1;
        repeat (120) begin
            if ($urandom_range(0, 99) < 25) send_item(random_write(w, h));
            else send_sample(random_sample());
        end
        wait_drained();
        no_idle = 1'b0;
    endtask

    // The result side holds off while samples keep coming, so the block
    // fills up and raises full; the sender then waits for all results.
    task automatic test_output_stall();
        set_sizes(9'd4, 9'd4);
        no_idle = 1'b1;
        hold_kick = ~hold_kick;
        repeat (40) send_sample(random_sample());
        wait_drained();
        no_idle = 1'b0;
    endtask

    // Reset, then the tests in turn, then the verdict.
    initial begin
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_item <= '0;
        pop <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_sizes();
        test_size_limits();
        test_random_phases();
        test_back_to_back();
        test_output_stall();
        wait_drained();
        if (err_count == 0) begin
            $display("bilinear_texture_sampler_top verification clean");
        end else begin
            $display("bilinear_texture_sampler_top verification failed");
        end
        $finish;
    end

endmodule
